@@ hdl/khnc_pkg.sv @@
// Package for the k-mer Hamming neighbor count unit.
// Holds the command and status codes, field widths and the sequencer state type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package khnc_pkg;

    // Fixed field widths.
    localparam int KMER_W   = 64;
    localparam int BASES    = KMER_W / 2;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int NBR_W    = 7;
    localparam int LEN_W    = 6;

    // Reset value of the k-mer length register.
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd21;

    // Command codes; the fourth code is unused.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Register byte address of kmer_length, decoded on the word index bit.
    localparam logic REG_KMER_LENGTH = 1'b0;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage : khnc_pkg

`default_nettype wire

@@ hdl/khnc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the k-mer store. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module khnc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                       aclk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : khnc_ram

`default_nettype wire

@@ hdl/kmer_hamming_neighbor_count_unit.sv @@
// K-mer set with insert, clear and Hamming-one neighbor count.
// Uses khnc_pkg and one khnc_ram instance for the k-mer store.
// An insert or a query walks the held entries once through one shared compare
// unit, one entry per cycle at the store's single read port. After the walk,
// S_LAST compares the last entry and S_FINISH loads the result into the output
// register. On an empty set, and for a clear or an unused command, the
// sequencer goes straight from S_IDLE to S_FINISH. It returns to S_IDLE as the
// result is loaded, and takes a new transaction only in S_IDLE, so one
// transaction is handled at a time. A result still waiting in the output
// register delays the load by the length of the stall.
// The compare unit checks each entry for equality with the k-mer and for a
// single differing base below kmer_length; since entries are distinct, each
// one matches at most one substitution. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module kmer_hamming_neighbor_count_unit
    import khnc_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int MAX_K    = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input channel.
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [CMD_W-1:0]                     s_cmd,
    input  wire logic [KMER_W-1:0]                    s_kmer,
    // Result channel.
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [STATUS_W-1:0]                  m_status,
    output logic      [NBR_W-1:0]                     m_neighbor_count,
    output logic      [$clog2(CAPACITY+1)-1:0]        m_entry_count,
    // Configuration port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [FILL_W-1:0] CAP_FILL  = FILL_W'(CAPACITY);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_K);
    localparam logic [NBR_W-1:0]  MAX_NBR   = NBR_W'(3 * MAX_K);

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KMER_W-1:0]    kmer_reg, kmer_next;
    logic [BASES-1:0]     len_mask_reg, len_mask_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 found_reg, found_next;
    logic [NBR_W-1:0]     nbr_reg, nbr_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [LEN_W-1:0]     klen_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [NBR_W-1:0]     m_nbr_reg, m_nbr_next;
    logic [FILL_W-1:0]    m_cnt_reg, m_cnt_next;

    logic                 ram_we;
    logic [KMER_W-1:0]    ram_rd_data;
    logic [LEN_W-1:0]     len_eff;
    logic [BASES-1:0]     len_mask;
    logic [KMER_W-1:0]    diff;
    logic [BASES-1:0]     base_diff;
    logic                 hit_eq;
    logic                 hit_nb;
    logic                 cfg_wr;

    // Configuration port: always ready, one register at word index zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_KMER_LENGTH) ? 32'(klen_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg <= LEN_RESET;
        end else if (cfg_wr && (paddr[2] == REG_KMER_LENGTH)) begin
            klen_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Positions tried by a query: the length saturates at MAX_K.
    assign len_eff = (klen_reg > MAX_LEN) ? MAX_LEN : klen_reg;

    always_comb begin
        for (int i = 0; i < BASES; i++) begin
            len_mask[i] = LEN_W'(i) < len_eff;
        end
    end

    // K-mer store.
    khnc_ram #(
        .WIDTH(KMER_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (kmer_reg),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Shared compare unit: equality and a single differing base in range.
    assign diff = ram_rd_data ^ kmer_reg;

    always_comb begin
        for (int i = 0; i < BASES; i++) begin
            base_diff[i] = |diff[2*i +: 2];
        end
    end

    assign hit_eq = (diff == '0);
    assign hit_nb = (base_diff != '0) &&
                    ((base_diff & (base_diff - 1'b1)) == '0) &&
                    ((base_diff & ~len_mask_reg) == '0);

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        kmer_next     = kmer_reg;
        len_mask_next = len_mask_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        nbr_next      = nbr_reg;
        fill_next     = fill_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_nbr_next    = m_nbr_reg;
        m_cnt_next    = m_cnt_reg;
        rd_vld_next   = state_reg == S_SCAN;
        ram_we        = 1'b0;

        // Output register drains when the consumer takes the result.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Accumulate compare results one entry behind the read address.
        if (rd_vld_reg) begin
            if (hit_eq) begin
                found_next = 1'b1;
            end
            if (hit_nb) begin
                nbr_next = nbr_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next      = s_cmd;
                    kmer_next     = s_kmer;
                    len_mask_next = len_mask;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    nbr_next      = '0;
                    case (s_cmd) inside
                        CMD_INSERT, CMD_QUERY: begin
                            state_next = (fill_reg == '0) ? S_FINISH : S_SCAN;
                        end
                        CMD_CLEAR: begin
                            fill_next  = '0;
                            state_next = S_FINISH;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (FILL_W'(idx_reg) == fill_reg - FILL_W'(1)) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_nbr_next    = (cmd_reg == CMD_QUERY) ? nbr_reg : '0;
                    if (cmd_reg == CMD_INSERT) begin
                        if (found_reg) begin
                            m_status_next = ST_PRESENT;
                        end else if (fill_reg == CAP_FILL) begin
                            m_status_next = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    m_cnt_next = fill_next;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_vld_reg  <= 1'b0;
            fill_reg    <= '0;
            nbr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            fill_reg    <= fill_next;
            nbr_reg     <= nbr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        kmer_reg     <= kmer_next;
        len_mask_reg <= len_mask_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_nbr_reg    <= m_nbr_next;
        m_cnt_reg    <= m_cnt_next;
    end

    assign s_ready          = state_reg == S_IDLE;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_neighbor_count = m_nbr_reg;
    assign m_entry_count    = m_cnt_reg;

`ifndef ASSERT_OFF
    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_FILL)
        else $error("fill count above capacity");

    // The store is written only below the capacity.
    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (fill_reg < CAP_FILL))
        else $error("store write with the set full");

    // Distinct entries bound the neighbor count by three per position.
    a_nbr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nbr_reg <= MAX_NBR)
        else $error("neighbor count out of range");

    // A dropped insert reports a full set.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_entry_count == CAP_FILL))
        else $error("full status with room left");

    // The sequencer is busy in the cycle after a transaction is accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after an accepted transaction");
`endif

endmodule : kmer_hamming_neighbor_count_unit

`default_nettype wire
